FILE: sv/avr_alu_with_status_flags_assert.svh
// Assertion macros used by the ALU top module.
// Each one expects clk_i and rst_ni in scope.
`ifndef AVR_ALU_WITH_STATUS_FLAGS_ASSERT_SVH
`define AVR_ALU_WITH_STATUS_FLAGS_ASSERT_SVH

// Same-cycle implication, checked out of reset
`define AVR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset
`define AVR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/avr_alu_pkg.sv
package avr_alu_pkg;

  // Operation codes
  localparam logic [4:0] OP_ADD   = 5'd0;
  localparam logic [4:0] OP_ADC   = 5'd1;
  localparam logic [4:0] OP_SUB   = 5'd2;
  localparam logic [4:0] OP_SBC   = 5'd3;
  localparam logic [4:0] OP_CP    = 5'd4;
  localparam logic [4:0] OP_CPC   = 5'd5;
  localparam logic [4:0] OP_AND   = 5'd6;
  localparam logic [4:0] OP_OR    = 5'd7;
  localparam logic [4:0] OP_EOR   = 5'd8;
  localparam logic [4:0] OP_COM   = 5'd9;
  localparam logic [4:0] OP_NEG   = 5'd10;
  localparam logic [4:0] OP_INC   = 5'd11;
  localparam logic [4:0] OP_DEC   = 5'd12;
  localparam logic [4:0] OP_LSR   = 5'd13;
  localparam logic [4:0] OP_ASR   = 5'd14;
  localparam logic [4:0] OP_ROR   = 5'd15;
  localparam logic [4:0] OP_SWAP  = 5'd16;
  localparam logic [4:0] OP_ADIW  = 5'd17;
  localparam logic [4:0] OP_SBIW  = 5'd18;
  localparam logic [4:0] OP_MUL   = 5'd19;
  localparam logic [4:0] OP_MULS  = 5'd20;
  localparam logic [4:0] OP_MULSU = 5'd21;
  localparam logic [4:0] OP_FMUL  = 5'd22;
  localparam logic [4:0] OP_BST   = 5'd23;
  localparam logic [4:0] OP_BLD   = 5'd24;

  // Status byte bit positions
  localparam int unsigned FLAG_C = 0;
  localparam int unsigned FLAG_Z = 1;
  localparam int unsigned FLAG_N = 2;
  localparam int unsigned FLAG_V = 3;
  localparam int unsigned FLAG_S = 4;
  localparam int unsigned FLAG_H = 5;
  localparam int unsigned FLAG_T = 6;

  // Flag update masks over bits T..C
  localparam logic [6:0] MASK_NONE  = 7'b0000000;
  localparam logic [6:0] MASK_ARITH = 7'b0111111;
  localparam logic [6:0] MASK_LOGIC = 7'b0011110;
  localparam logic [6:0] MASK_NZVSC = 7'b0011111;
  localparam logic [6:0] MASK_MUL   = 7'b0000011;
  localparam logic [6:0] MASK_T     = 7'b1000000;

  // Execute-stage result handed to the flag stage
  typedef struct packed {
    logic [15:0] val;
    logic [7:0]  fin;
    logic        c;
    logic        h;
    logic        v;
    logic        t;
    logic [6:0]  mask;
    logic        wide;
    logic        chain_z;
    logic        wr;
  } exec_t;

endpackage

FILE: sv/avr_alu_exec.sv
module avr_alu_exec (
  input  logic [4:0]          op_i,
  input  logic [15:0]         dw_i,
  input  logic [7:0]          r_i,
  input  logic [2:0]          bi_i,
  input  logic [7:0]          fin_i,
  output avr_alu_pkg::exec_t  ex_o
);
  import avr_alu_pkg::*;

  logic [7:0]  d;
  logic        cin;
  logic [7:0]  add_res, add_cv;
  logic        add_v;
  logic [7:0]  sub_a, sub_b, sub_res, sub_bv;
  logic        sub_v, sub_bin;
  logic [15:0] word_res;
  logic        sgn_d, sgn_r;
  logic signed [8:0]  mul_a, mul_b;
  logic signed [17:0] prod;
  logic [7:0]  shr_res, bld_res;

  assign d   = dw_i[7:0];
  assign cin = fin_i[FLAG_C];

  // Byte add with optional carry in
  assign add_res = d + r_i + {7'd0, (op_i == OP_ADC) & cin};
  assign add_cv  = (d & r_i) | (r_i & ~add_res) | (~add_res & d);
  assign add_v   = (d[7] & r_i[7] & ~add_res[7]) | (~d[7] & ~r_i[7] & add_res[7]);

  // Byte subtract; negate is zero minus the operand
  assign sub_a   = (op_i == OP_NEG) ? 8'd0 : d;
  assign sub_b   = (op_i == OP_NEG) ? d : r_i;
  assign sub_bin = ((op_i == OP_SBC) || (op_i == OP_CPC)) & cin;
  assign sub_res = sub_a - sub_b - {7'd0, sub_bin};
  assign sub_bv  = (~sub_a & sub_b) | (sub_b & sub_res) | (sub_res & ~sub_a);
  assign sub_v   = (sub_a[7] & ~sub_b[7] & ~sub_res[7]) | (~sub_a[7] & sub_b[7] & sub_res[7]);

  // Word add or subtract of a six-bit immediate
  assign word_res = (op_i == OP_SBIW) ? dw_i - {10'd0, r_i[5:0]}
                                      : dw_i + {10'd0, r_i[5:0]};

  // One signed 9x9 multiplier serves every multiply flavour
  assign sgn_d = (op_i == OP_MULS) || (op_i == OP_MULSU);
  assign sgn_r = (op_i == OP_MULS);
  assign mul_a = $signed({sgn_d & d[7], d});
  assign mul_b = $signed({sgn_r & r_i[7], r_i});
  assign prod  = mul_a * mul_b;

  // Right shifts: fill the top bit by operation
  always_comb begin
    shr_res = {1'b0, d[7:1]};
    if (op_i == OP_ASR) begin
      shr_res[7] = d[7];
    end else if (op_i == OP_ROR) begin
      shr_res[7] = cin;
    end
  end

  // Bit load from T
  always_comb begin
    bld_res = d;
    bld_res[bi_i] = fin_i[FLAG_T];
  end

  // Select the result and the raw C, H, V, T per operation
  always_comb begin
    ex_o         = '0;
    ex_o.fin     = fin_i;
    ex_o.wr      = 1'b1;
    unique case (op_i)
      OP_ADD, OP_ADC: begin
        ex_o.val  = {8'd0, add_res};
        ex_o.c    = add_cv[7];
        ex_o.h    = add_cv[3];
        ex_o.v    = add_v;
        ex_o.mask = MASK_ARITH;
      end
      OP_SUB, OP_SBC, OP_CP, OP_CPC, OP_NEG: begin
        ex_o.val     = {8'd0, sub_res};
        ex_o.c       = sub_bv[7];
        ex_o.h       = sub_bv[3];
        ex_o.v       = sub_v;
        ex_o.mask    = MASK_ARITH;
        ex_o.chain_z = (op_i == OP_SBC) || (op_i == OP_CPC);
        ex_o.wr      = (op_i != OP_CP) && (op_i != OP_CPC);
      end
      OP_AND, OP_OR, OP_EOR: begin
        ex_o.val  = {8'd0, (op_i == OP_AND) ? (d & r_i) :
                           (op_i == OP_OR)  ? (d | r_i) : (d ^ r_i)};
        ex_o.mask = MASK_LOGIC;
      end
      OP_COM: begin
        ex_o.val  = {8'd0, ~d};
        ex_o.c    = 1'b1;
        ex_o.mask = MASK_NZVSC;
      end
      OP_INC: begin
        ex_o.val  = {8'd0, d + 8'd1};
        ex_o.v    = (d == 8'h7F);
        ex_o.mask = MASK_LOGIC;
      end
      OP_DEC: begin
        ex_o.val  = {8'd0, d - 8'd1};
        ex_o.v    = (d == 8'h80);
        ex_o.mask = MASK_LOGIC;
      end
      OP_LSR, OP_ASR, OP_ROR: begin
        ex_o.val  = {8'd0, shr_res};
        ex_o.c    = d[0];
        ex_o.v    = shr_res[7] ^ d[0];
        ex_o.mask = MASK_NZVSC;
      end
      OP_SWAP: begin
        ex_o.val  = {8'd0, d[3:0], d[7:4]};
      end
      OP_ADIW: begin
        ex_o.val  = word_res;
        ex_o.v    = ~dw_i[15] & word_res[15];
        ex_o.c    = dw_i[15] & ~word_res[15];
        ex_o.mask = MASK_NZVSC;
        ex_o.wide = 1'b1;
      end
      OP_SBIW: begin
        ex_o.val  = word_res;
        ex_o.v    = dw_i[15] & ~word_res[15];
        ex_o.c    = ~dw_i[15] & word_res[15];
        ex_o.mask = MASK_NZVSC;
        ex_o.wide = 1'b1;
      end
      OP_MUL, OP_MULS, OP_MULSU: begin
        ex_o.val  = prod[15:0];
        ex_o.c    = prod[15];
        ex_o.mask = MASK_MUL;
        ex_o.wide = 1'b1;
      end
      OP_FMUL: begin
        // carry is taken before the shift
        ex_o.val  = {prod[14:0], 1'b0};
        ex_o.c    = prod[15];
        ex_o.mask = MASK_MUL;
        ex_o.wide = 1'b1;
      end
      OP_BST: begin
        ex_o.t    = d[bi_i];
        ex_o.mask = MASK_T;
        ex_o.wr   = 1'b0;
      end
      OP_BLD: begin
        ex_o.val  = {8'd0, bld_res};
      end
      default: begin
        ex_o.mask = MASK_NONE;
        ex_o.wr   = 1'b0;
      end
    endcase
  end

endmodule

FILE: sv/avr_alu_flags.sv
module avr_alu_flags (
  input  avr_alu_pkg::exec_t ex_i,
  output logic [7:0]         flags_o
);
  import avr_alu_pkg::*;

  logic       n, z, s;
  logic [6:0] upd;

  // Derive N, Z and S from the byte or the word result
  always_comb begin
    n = ex_i.wide ? ex_i.val[15] : ex_i.val[7];
    z = ex_i.wide ? (ex_i.val == 16'd0) : (ex_i.val[7:0] == 8'd0);
    if (ex_i.chain_z) begin
      z = z & ex_i.fin[FLAG_Z];
    end
    s = n ^ ex_i.v;
  end

  // Merge the updated bits; untouched flags and I pass through
  always_comb begin
    upd = '0;
    upd[FLAG_C] = ex_i.c;
    upd[FLAG_Z] = z;
    upd[FLAG_N] = n;
    upd[FLAG_V] = ex_i.v;
    upd[FLAG_S] = s;
    upd[FLAG_H] = ex_i.h;
    upd[FLAG_T] = ex_i.t;
    flags_o = {ex_i.fin[7], (ex_i.fin[6:0] & ~ex_i.mask) | (upd & ex_i.mask)};
  end

endmodule

FILE: sv/avr_alu_with_status_flags.sv
// AVR-style ALU with status flags, three register stages:
// input capture, execute (adders and the 9x9 multiplier), flag merge.
// An accepted request passes the capture, execute and output registers in turn.
// Throughput: one operation per cycle while out_stall_i is low; a full stage holds when the next cannot move on.
// Reset: rst_ni (asynchronous, active low) clears all stage valid bits.
module avr_alu_with_status_flags (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [4:0]  req_type_i,
  input  logic [15:0] operand_d_i,
  input  logic [7:0]  operand_r_i,
  input  logic [2:0]  bit_index_i,
  input  logic [7:0]  flags_in_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [15:0] result_value_o,
  output logic [7:0]  flags_out_o,
  output logic        writes_result_o
);
  import avr_alu_pkg::*;

  logic        va_q, vb_q, vc_q;
  logic        rdy_a, rdy_b, rdy_c;
  logic        in_xfer;
  logic [4:0]  op_q;
  logic [15:0] dw_q;
  logic [7:0]  r_q;
  logic [2:0]  bi_q;
  logic [7:0]  fin_q;
  exec_t       ex_d, ex_q;
  logic [7:0]  flags_d;
  logic [15:0] res_q;
  logic [7:0]  flags_q;
  logic        wr_q;

  // Each stage loads when empty or when the next one moves on
  assign rdy_c   = !vc_q || !out_stall_i;
  assign rdy_b   = !vb_q || rdy_c;
  assign rdy_a   = !va_q || rdy_b;
  assign in_stall_o = !rdy_a;
  assign in_xfer = in_valid_i && rdy_a;

  // Advance the valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
    end else begin
      if (rdy_a) va_q <= in_valid_i;
      if (rdy_b) vb_q <= va_q;
      if (rdy_c) vc_q <= vb_q;
    end
  end

  // Capture the request
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      op_q  <= req_type_i;
      dw_q  <= operand_d_i;
      r_q   <= operand_r_i;
      bi_q  <= bit_index_i;
      fin_q <= flags_in_i;
    end
  end

  avr_alu_exec u_exec (
    .op_i  (op_q),
    .dw_i  (dw_q),
    .r_i   (r_q),
    .bi_i  (bi_q),
    .fin_i (fin_q),
    .ex_o  (ex_d)
  );

  // Hold the execute result
  always_ff @(posedge clk_i) begin
    if (rdy_b && va_q) begin
      ex_q <= ex_d;
    end
  end

  avr_alu_flags u_flags (
    .ex_i    (ex_q),
    .flags_o (flags_d)
  );

  // Output register
  always_ff @(posedge clk_i) begin
    if (rdy_c && vb_q) begin
      res_q   <= ex_q.val;
      flags_q <= flags_d;
      wr_q    <= ex_q.wr;
    end
  end

  assign out_valid_o     = vc_q;
  assign result_value_o  = res_q;
  assign flags_out_o     = flags_q;
  assign writes_result_o = wr_q;

`include "avr_alu_with_status_flags_assert.svh"

  `AVR_ASSERT_NEXT(a_in_lands, in_xfer, va_q, "accepted item missing from first stage")
  `AVR_ASSERT_NOW(a_stall_full, 1'b1, in_stall_o == (va_q && vb_q && vc_q && out_stall_i), "stall does not match a full blocked pipe")
  `AVR_ASSERT_NEXT(a_mid_hold, vb_q && !rdy_b, vb_q && $stable(ex_q), "blocked execute stage lost its item")
  `AVR_ASSERT_NEXT(a_out_load, vb_q && rdy_c, vc_q, "execute result not moved to output")

endmodule
